// ===== rtl/core/bdsc_pkg.sv =====
// Package for the bencode dictionary scanner.
// Holds the character codes, status, error and entry type codes, and parameter defaults.
// No dependencies.
package bdsc_pkg;

  localparam int unsigned MaxDepthDefault   = 32;
  localparam int unsigned OffsetBitsDefault = 16;

  localparam logic [7:0] CHAR_D     = 8'h64;  // 'd'
  localparam logic [7:0] CHAR_L     = 8'h6C;  // 'l'
  localparam logic [7:0] CHAR_I     = 8'h69;  // 'i'
  localparam logic [7:0] CHAR_E     = 8'h65;  // 'e'
  localparam logic [7:0] CHAR_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [1:0] STATUS_MORE = 2'd0;
  localparam logic [1:0] STATUS_DONE = 2'd1;
  localparam logic [1:0] STATUS_STOP = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_KEY_TYPE  = 3'd1;
  localparam logic [2:0] ERR_NOT_DICT  = 3'd2;
  localparam logic [2:0] ERR_ODD       = 3'd3;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd5;
  localparam logic [2:0] ERR_TOO_DEEP  = 3'd6;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd7;

  localparam logic [1:0] TYPE_INT  = 2'd0;
  localparam logic [1:0] TYPE_STR  = 2'd1;
  localparam logic [1:0] TYPE_DICT = 2'd2;
  localparam logic [1:0] TYPE_LIST = 2'd3;
  localparam logic [1:0] KIND_NONE = 2'd0;

endpackage

// ===== rtl/core/bencode_dictionary_scanner.sv =====
// Bencode dictionary scanner top level: byte scanner, nesting stack memory, result register.
// Depends on bdsc_pkg.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid_i/in_ready_o, data_byte_i,   | input
//           | restart_i                             |
//   out     | out_valid_o/out_ready_i, status_o ..  | output
//           | int_value_o                           |
//
// Each accepted byte yields exactly one result item, registered for the next cycle;
// a new byte is taken every cycle while the output is not stalled. The stack memory
// sets the rate: the top of stack sits in flip-flops and the entry under it is read
// ahead each cycle from the one-port-write, one-port-read memory; push and pop never wait.
// Reset clears all control state; the stack memory needs no clearing.
// A stalled output holds its item and stops intake until it is taken.
module bencode_dictionary_scanner #(
  parameter int unsigned MAX_DEPTH   = bdsc_pkg::MaxDepthDefault,
  parameter int unsigned OFFSET_BITS = bdsc_pkg::OffsetBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [2:0]         error_code_o,
  output logic               entry_valid_o,
  output logic [1:0]         entry_type_o,
  output logic [15:0]        key_offset_o,
  output logic [15:0]        key_length_o,
  output logic [15:0]        value_offset_o,
  output logic [15:0]        value_length_o,
  output logic signed [63:0] int_value_o
);
  import bdsc_pkg::*;

  localparam int unsigned OB = OFFSET_BITS;
  localparam int unsigned AW = $clog2(MAX_DEPTH);
  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam logic [OB+3:0] LenMax  = {4'b0, {OB{1'b1}}};
  localparam logic [OB:0]   PosMax  = {1'b0, {OB{1'b1}}};
  localparam logic [DW-1:0] DepthMx = DW'(MAX_DEPTH);

  typedef enum logic [2:0] {
    MODE_EMPTY, MODE_INT_SIGN, MODE_INT_FIRST, MODE_INT_MORE, MODE_LEN, MODE_SKIP
  } mode_e;

  // scanner state
  mode_e          mode_q, mode_d;
  logic [DW-1:0]  depth_q, depth_d;
  logic           top_kind_q, top_kind_d;   // 1 dictionary, 0 list
  logic           top_par_q, top_par_d;     // 1 key seen, value pending
  logic [OB-1:0]  len_q, len_d;
  logic [OB-1:0]  rem_q, rem_d;
  logic [63:0]    iacc_q, iacc_d;
  logic           ineg_q, ineg_d;
  logic [OB:0]    pos_q, pos_d;
  logic [OB-1:0]  hko_q, hko_d;
  logic [OB-1:0]  hkl_q, hkl_d;
  logic           hkv_q, hkv_d;
  logic [OB-1:0]  raw_start_q, raw_start_d;
  logic [1:0]     raw_kind_q, raw_kind_d;
  logic           done_q, done_d;
  logic           stop_q, stop_d;
  logic [2:0]     herr_q, herr_d;

  // stack memory: entries under the top, {kind, parity}
  logic [1:0]     stack_mem [MAX_DEPTH];
  logic [1:0]     below_q;
  logic           we;
  logic [AW-1:0]  wa, ra;
  logic [1:0]     wd;

  // result register
  logic        out_valid_q;
  logic [1:0]  status_q, status_d;
  logic [2:0]  errc_q, errc_d;
  logic        ev_q, ev_d;
  logic [1:0]  et_q, et_d;
  logic [15:0] ko_q, ko_d, kl_q, kl_d, vo_q, vo_d, vl_q, vl_d;
  logic [63:0] iv_q, iv_d;

  logic accept;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  function automatic logic [15:0] to16(input logic [OB-1:0] x);
    logic [31:0] t;
    t = 32'(x);
    return t[15:0];
  endfunction

  always_comb begin
    logic [7:0]    c;
    logic          digit;
    logic [3:0]    dval;
    logic [2:0]    err;
    logic [OB:0]   pos;
    logic          key_slot;
    logic          push;
    logic          sdone;
    logic          emit;
    logic [1:0]    emit_type;
    logic [15:0]   emit_vo, emit_vl;
    logic [63:0]   emit_iv;
    logic          add_dig;
    logic [67:0]   prod;
    logic [67:0]   limit;
    logic [OB+3:0] nlen;
    logic [OB:0]   pos_inc;
    logic [OB:0]   rawlen;

    c     = data_byte_i;
    digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    dval  = 4'(c - CHAR_ZERO);
    err   = ERR_NONE;
    push  = 1'b0;
    sdone = 1'b0;
    emit  = 1'b0;
    emit_type = TYPE_INT;
    emit_vo = '0;
    emit_vl = '0;
    emit_iv = '0;
    add_dig = 1'b0;
    prod    = '0;
    limit   = '0;
    nlen    = '0;
    pos_inc = '0;
    rawlen  = '0;

    // restart clears the state before this byte is scanned
    if (restart_i) begin
      mode_d = MODE_EMPTY; depth_d = '0; top_kind_d = 1'b0; top_par_d = 1'b0;
      len_d = '0; rem_d = '0; iacc_d = '0; ineg_d = 1'b0; pos_d = '0;
      hko_d = '0; hkl_d = '0; hkv_d = 1'b0; raw_start_d = '0; raw_kind_d = KIND_NONE;
      done_d = 1'b0; stop_d = 1'b0; herr_d = ERR_NONE;
    end else begin
      mode_d = mode_q; depth_d = depth_q; top_kind_d = top_kind_q; top_par_d = top_par_q;
      len_d = len_q; rem_d = rem_q; iacc_d = iacc_q; ineg_d = ineg_q; pos_d = pos_q;
      hko_d = hko_q; hkl_d = hkl_q; hkv_d = hkv_q; raw_start_d = raw_start_q;
      raw_kind_d = raw_kind_q; done_d = done_q; stop_d = stop_q; herr_d = herr_q;
    end

    wa = AW'(depth_d - DW'(1));
    wd = {top_kind_d, top_par_d};
    key_slot = (depth_d != '0) && top_kind_d && !top_par_d;
    pos = pos_d;

    status_d = STATUS_MORE;
    errc_d   = ERR_NONE;

    if (stop_d) begin
      status_d = STATUS_STOP;
      errc_d   = herr_d;
    end else if (done_d) begin
      status_d = STATUS_DONE;
    end else if (pos_d > PosMax) begin
      err = ERR_TOO_LONG;
    end else begin
      pos_d = pos_d + 1'b1;
      unique case (mode_d)
        MODE_EMPTY: begin
          if (c == CHAR_D || c == CHAR_L) begin
            if (depth_d == '0 && c == CHAR_L) err = ERR_NOT_DICT;
            else if (depth_d != '0 && key_slot) err = ERR_KEY_TYPE;
            else if (depth_d >= DepthMx) err = ERR_TOO_DEEP;
            else begin
              if (depth_d == DW'(1)) begin
                raw_start_d = pos[OB-1:0];
                raw_kind_d  = (c == CHAR_D) ? TYPE_DICT : TYPE_LIST;
              end
              push       = (depth_d != '0);
              top_kind_d = (c == CHAR_D);
              top_par_d  = 1'b0;
              depth_d    = depth_d + 1'b1;
            end
          end else if (c == CHAR_I) begin
            if (depth_d == '0) err = ERR_NOT_DICT;
            else if (key_slot) err = ERR_KEY_TYPE;
            else begin
              iacc_d = '0;
              ineg_d = 1'b0;
              mode_d = MODE_INT_SIGN;
            end
          end else if (c == CHAR_E) begin
            if (depth_d == '0) err = ERR_NOT_DICT;
            else if (top_kind_d && top_par_d) err = ERR_ODD;
            else begin
              if (depth_d == DW'(2) && hkv_d && raw_kind_d != KIND_NONE) begin
                rawlen    = pos - {1'b0, raw_start_d} + 1'b1;
                emit      = 1'b1;
                emit_type = raw_kind_d;
                emit_vo   = to16(raw_start_d);
                emit_vl   = to16(rawlen[OB-1:0]);
              end
              if (depth_d == DW'(2)) raw_kind_d = KIND_NONE;
              depth_d = depth_d - 1'b1;
              if (depth_d == '0) done_d = 1'b1;
              else begin
                // pop: the entry under the top was read ahead
                top_kind_d = below_q[1];
                top_par_d  = ~below_q[0];
              end
            end
          end else if (digit) begin
            if (depth_d == '0) err = ERR_NOT_DICT;
            else begin
              len_d  = OB'(dval);
              mode_d = MODE_LEN;
            end
          end else begin
            err = ERR_BAD_CHAR;
          end
        end
        MODE_INT_SIGN, MODE_INT_FIRST: begin
          if (mode_d == MODE_INT_SIGN && c == CHAR_MINUS) begin
            ineg_d = 1'b1;
            mode_d = MODE_INT_FIRST;
          end else if (!digit) err = ERR_BAD_CHAR;
          else begin
            mode_d  = MODE_INT_MORE;
            add_dig = 1'b1;
          end
        end
        MODE_INT_MORE: begin
          if (c == CHAR_E) begin
            if (depth_d == DW'(1) && hkv_d) begin
              emit      = 1'b1;
              emit_type = TYPE_INT;
              emit_iv   = ineg_d ? (64'd0 - iacc_d) : iacc_d;
            end
            if (depth_d != '0) top_par_d = ~top_par_d;
            mode_d = MODE_EMPTY;
          end else if (!digit) err = ERR_BAD_CHAR;
          else add_dig = 1'b1;
        end
        MODE_LEN: begin
          if (digit) begin
            nlen  = ({4'b0, len_d} << 3) + ({4'b0, len_d} << 1) + (OB+4)'(dval);
            len_d = nlen[OB-1:0];
            if (nlen > LenMax) err = ERR_OVERFLOW;
          end else if (c != CHAR_COLON) err = ERR_BAD_CHAR;
          else begin
            if (depth_d == DW'(1)) begin
              pos_inc     = pos + 1'b1;
              raw_start_d = pos_inc[OB-1:0];
              if (!top_par_d) begin
                hko_d = raw_start_d;
                hkl_d = len_d;
                hkv_d = 1'b1;
              end
            end
            rem_d = len_d;
            if (len_d == '0) sdone = 1'b1;
            else mode_d = MODE_SKIP;
          end
        end
        MODE_SKIP: begin
          if (rem_d != '0) rem_d = rem_d - 1'b1;
          if (rem_d == '0) sdone = 1'b1;
        end
        default: begin
          mode_d = MODE_EMPTY;
          err    = ERR_BAD_CHAR;
        end
      endcase

      if (add_dig) begin
        limit = ineg_d ? 68'h0_8000_0000_0000_0000 : 68'h0_7FFF_FFFF_FFFF_FFFF;
        prod  = ({4'b0, iacc_d} << 3) + ({4'b0, iacc_d} << 1) + 68'(dval);
        if (prod > limit) err = ERR_OVERFLOW;
        else iacc_d = prod[63:0];
      end

      // string complete: report a top-level value, toggle key/value parity
      if (sdone) begin
        if (depth_d == DW'(1) && top_par_d && hkv_d) begin
          emit      = 1'b1;
          emit_type = TYPE_STR;
          emit_vo   = to16(raw_start_d);
          emit_vl   = to16(len_d);
        end
        if (depth_d != '0) top_par_d = ~top_par_d;
        mode_d = MODE_EMPTY;
      end
    end

    ev_d = 1'b0; et_d = '0; ko_d = '0; kl_d = '0; vo_d = '0; vl_d = '0; iv_d = '0;
    if (emit) begin
      ev_d = 1'b1;
      et_d = emit_type;
      ko_d = to16(hko_d);
      kl_d = to16(hkl_d);
      vo_d = emit_vo;
      vl_d = emit_vl;
      iv_d = emit_iv;
      hkv_d = 1'b0;
      hko_d = '0;
      hkl_d = '0;
    end

    if (err != ERR_NONE) begin
      ev_d = 1'b0; et_d = '0; ko_d = '0; kl_d = '0; vo_d = '0; vl_d = '0; iv_d = '0;
      stop_d   = 1'b1;
      herr_d   = err;
      status_d = STATUS_STOP;
      errc_d   = err;
      push     = 1'b0;
    end else if (!stop_d && done_d) begin
      status_d = STATUS_DONE;
    end

    we = accept && push;
    // read ahead the entry under the new top
    ra = AW'(accept ? depth_d - DW'(2) : depth_q - DW'(2));
  end

  // stack memory: one write, one registered read, write forwarded to the read
  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_mem[wa] <= wd;
    end
    if (we && wa == ra) begin
      below_q <= wd;
    end else begin
      below_q <= stack_mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_EMPTY;
      depth_q     <= '0;
      top_kind_q  <= 1'b0;
      top_par_q   <= 1'b0;
      len_q       <= '0;
      rem_q       <= '0;
      iacc_q      <= '0;
      ineg_q      <= 1'b0;
      pos_q       <= '0;
      hko_q       <= '0;
      hkl_q       <= '0;
      hkv_q       <= 1'b0;
      raw_start_q <= '0;
      raw_kind_q  <= KIND_NONE;
      done_q      <= 1'b0;
      stop_q      <= 1'b0;
      herr_q      <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q      <= mode_d;
        depth_q     <= depth_d;
        top_kind_q  <= top_kind_d;
        top_par_q   <= top_par_d;
        len_q       <= len_d;
        rem_q       <= rem_d;
        iacc_q      <= iacc_d;
        ineg_q      <= ineg_d;
        pos_q       <= pos_d;
        hko_q       <= hko_d;
        hkl_q       <= hkl_d;
        hkv_q       <= hkv_d;
        raw_start_q <= raw_start_d;
        raw_kind_q  <= raw_kind_d;
        done_q      <= done_d;
        stop_q      <= stop_d;
        herr_q      <= herr_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      errc_q   <= errc_d;
      ev_q     <= ev_d;
      et_q     <= et_d;
      ko_q     <= ko_d;
      kl_q     <= kl_d;
      vo_q     <= vo_d;
      vl_q     <= vl_d;
      iv_q     <= iv_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign error_code_o   = errc_q;
  assign entry_valid_o  = ev_q;
  assign entry_type_o   = et_q;
  assign key_offset_o   = ko_q;
  assign key_length_o   = kl_q;
  assign value_offset_o = vo_q;
  assign value_length_o = vl_q;
  assign int_value_o    = iv_q;

endmodule
